FILE: hw/rtl/trfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_pkg: shared types and constants of the three-relay fill sequencer
// Holds the mode codes, register indexes, item and result layouts and the
// architectural state record used by the step logic and the top level.
// ----------------------------------------------------------------------------
package trfs_pkg;

   // Mode codes, as they appear on the result channel.
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_SET1  = 3'd1;
   localparam logic [2:0] MODE_SET2  = 3'd2;
   localparam logic [2:0] MODE_SET3  = 3'd3;
   localparam logic [2:0] MODE_FILL  = 3'd4;
   localparam logic [2:0] MODE_LOCK  = 3'd5;

   // Fill phases: one per relay, then the closing phase.
   localparam logic [1:0] PHASE_RELAY1 = 2'd0;
   localparam logic [1:0] PHASE_RELAY2 = 2'd1;
   localparam logic [1:0] PHASE_RELAY3 = 2'd2;
   localparam logic [1:0] PHASE_END    = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_TICKS_PER_UNIT   = 1'b0;
   localparam logic CSR_SAFETY_THRESHOLD = 1'b1;

   localparam logic [7:0] TICKS_PER_UNIT_RESET   = 8'd75;
   localparam logic [9:0] SAFETY_THRESHOLD_RESET = 10'd150;

   localparam logic [6:0] SHARE_STEP  = 7'd10;
   localparam logic [7:0] SHARE_MAX   = 8'd100;
   localparam logic [8:0] SHARE_LIMIT = 9'd101;

   // Reciprocal of ten for the share-to-count conversion: (x * 205) >> 11.
   localparam logic [7:0] DIV10_MULT  = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   typedef struct packed {
      logic [9:0] fluid_level;
      logic       button_left;
      logic       button_right;
      logic       press_pending;
   } item_type;

   typedef struct packed {
      logic       press_consumed;
      logic [6:0] current_share;
      logic [1:0] active_relay;
      logic [2:0] mode;
   } result_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [1:0]       fill_phase;
      logic [6:0]       share_now;
      logic [6:0]       share_total;
      logic [2:0][3:0]  relay_counts;
      logic [15:0]      tick_count;
   } state_type;

   typedef struct packed {
      logic [7:0] ticks_per_unit;
      logic [9:0] safety_threshold;
   } cfg_type;

   // Share in percent to a count of tens.
   function automatic logic [3:0] share_to_count(input logic [6:0] share);
      logic [14:0] prod;
      prod = 15'(share) * 15'(DIV10_MULT);
      return prod[DIV10_SHIFT +: 4];
   endfunction

endpackage

FILE: hw/rtl/three_relay_timed_fill_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_relay_timed_fill_sequencer: button-driven share setup and timed fill
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    req_tdata: tick item
//   rsp      out        rsp_tvalid/tready    rsp_tdata: state after the tick
//   csr      in         csr_valid/ready      csr_index, csr_data
//
// One item per cycle while rsp_tready keeps the result register free; the accepting
// edge loads the input register, and the edge that advances it loads the result register.
// Reset clears the sequencer state and loads the register defaults.
// A stalled result register holds the input register, and req_tready drops
// only when both are full. csr_ready is always high.
// ----------------------------------------------------------------------------
module three_relay_timed_fill_sequencer
   import trfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] press_pending, [1] button_right, [2] button_left,
   // [12:3] fluid_level, [15:13] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] mode, [4:3] active_relay, [11:5] current_share,
   // [12] press_consumed, [15:13] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type out_res_in;
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  step_nxt;
   result_type step_res;
   logic       out_free;
   logic       advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   trfs_step u_step (
      .cur  (state_ff),
      .item (in_item_ff),
      .cfg  (cfg_ff),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      state_in     = state_ff;
      cfg_in       = cfg_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_item_in  = item_type'(req_tdata[12:0]);
      end
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
         state_in     = step_nxt;
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TICKS_PER_UNIT:   cfg_in.ticks_per_unit   = csr_data[7:0];
            CSR_SAFETY_THRESHOLD: cfg_in.safety_threshold = csr_data;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.ticks_per_unit   <= TICKS_PER_UNIT_RESET;
         cfg_ff.safety_threshold <= SAFETY_THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_res_ff};

   // Lockout holds until reset.
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_LOCK |=> state_ff.mode == MODE_LOCK)
      else $error("lockout mode left without reset");

   // A relay is reported only while filling.
   a_relay_in_fill: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.active_relay != 2'd0 |-> out_res_ff.mode == MODE_FILL)
      else $error("active relay reported outside fill mode");

   // A share is reported only in the setup modes.
   a_share_in_setup: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.current_share != 7'd0
         |-> out_res_ff.mode == MODE_SET1 || out_res_ff.mode == MODE_SET2
             || out_res_ff.mode == MODE_SET3)
      else $error("current share reported outside setup modes");

   // A held item is not dropped while the result side stalls.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("input item lost during result stall");

endmodule

FILE: hw/rtl/trfs_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_fill: timed fill sequencing for one tick in fill mode
// Compares the tick count with ticks_per_unit times the count of the relay
// in its phase, skips relays with a zero count and closes the fill.
// ----------------------------------------------------------------------------
module trfs_fill
   import trfs_pkg::*;
(
   input  state_type  cur,
   input  logic [7:0] ticks_per_unit,
   output state_type  nxt
);

   logic [3:0]  sel_count;
   logic [11:0] phase_ticks;
   logic        phase_done;
   logic        skip2;
   logic        skip3;

   always_comb begin
      case (cur.fill_phase)
         PHASE_RELAY1: sel_count = cur.relay_counts[0];
         PHASE_RELAY2: sel_count = cur.relay_counts[1];
         PHASE_RELAY3: sel_count = cur.relay_counts[2];
         default:      sel_count = 4'd0;
      endcase
   end

   assign phase_ticks = 12'(ticks_per_unit) * 12'(sel_count);
   assign phase_done  = cur.tick_count >= 16'(phase_ticks);
   assign skip2       = cur.relay_counts[1] == 4'd0;
   assign skip3       = cur.relay_counts[2] == 4'd0;

   always_comb begin
      logic [15:0] tick_base;
      nxt       = cur;
      tick_base = cur.tick_count;
      case (cur.fill_phase)
         PHASE_RELAY1: begin
            if (phase_done) begin
               nxt.fill_phase = PHASE_RELAY2 + 2'(skip2) + 2'(skip3);
               tick_base      = 16'd0;
            end
         end
         PHASE_RELAY2: begin
            if (phase_done) begin
               nxt.fill_phase = PHASE_RELAY3 + 2'(skip3);
               tick_base      = 16'd0;
            end
         end
         PHASE_RELAY3: begin
            if (phase_done) begin
               nxt.fill_phase = PHASE_END;
               tick_base      = 16'd0;
            end
         end
         default: begin
            nxt.fill_phase = PHASE_RELAY1;
            nxt.mode       = MODE_IDLE;
            tick_base      = 16'd0;
         end
      endcase
      nxt.tick_count = tick_base + 16'd1;
   end

endmodule

FILE: hw/rtl/trfs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_step: next state and result for one tick
// Applies button presses in idle and the setup modes, the fill sequencer in fill
// mode and the level lockout, and forms the result item.
// ----------------------------------------------------------------------------
module trfs_step
   import trfs_pkg::*;
(
   input  state_type  cur,
   input  item_type   item,
   input  cfg_type    cfg,
   output state_type  nxt,
   output result_type res
);

   state_type fill_nxt;

   trfs_fill u_fill (
      .cur            (cur),
      .ticks_per_unit (cfg.ticks_per_unit),
      .nxt            (fill_nxt)
   );

   always_comb begin
      logic       limit_ok;
      logic       consumed;
      logic [7:0] sum2;
      logic [8:0] sum3;
      nxt      = cur;
      consumed = 1'b0;
      limit_ok = 1'b0;
      sum2     = 8'(cur.share_total) + 8'(cur.share_now);
      sum3     = 9'(sum2) + 9'(SHARE_STEP);

      if (cur.mode == MODE_FILL) begin
         nxt = fill_nxt;
      end else if (item.press_pending && cur.mode <= MODE_SET3) begin
         if (cur.mode != MODE_IDLE && item.button_left) begin
            case (cur.mode)
               MODE_SET1: limit_ok = 8'(cur.share_now) < SHARE_MAX;
               MODE_SET2: limit_ok = sum2 < SHARE_MAX;
               default:   limit_ok = sum3 < SHARE_LIMIT;
            endcase
            if (limit_ok) begin
               nxt.share_now = cur.share_now + SHARE_STEP;
            end
            consumed = 1'b1;
         end
         if (item.button_right) begin
            // The right action sees the share as left by the left action.
            case (cur.mode)
               MODE_IDLE: begin
                  nxt.share_total = 7'd0;
               end
               MODE_SET1: begin
                  nxt.relay_counts[0] = share_to_count(nxt.share_now);
                  nxt.share_total     = nxt.share_now;
               end
               MODE_SET2: begin
                  nxt.share_total     = cur.share_total + nxt.share_now;
                  nxt.relay_counts[1] = share_to_count(nxt.share_now);
               end
               default: begin
                  if (cur.relay_counts[0] == 4'd0) begin
                     nxt.fill_phase = cur.fill_phase + 2'd1;
                  end
                  nxt.share_total     = cur.share_total + nxt.share_now;
                  nxt.relay_counts[2] = share_to_count(nxt.share_now);
               end
            endcase
            if (cur.mode != MODE_IDLE) begin
               nxt.share_now = 7'd0;
            end
            nxt.mode = cur.mode + 3'd1;
            consumed = 1'b1;
         end
      end

      if (item.fluid_level > cfg.safety_threshold) begin
         nxt.mode = MODE_LOCK;
      end

      res.mode           = nxt.mode;
      res.press_consumed = consumed;
      res.active_relay   = 2'd0;
      res.current_share  = 7'd0;
      if (nxt.mode == MODE_FILL && nxt.fill_phase != PHASE_END) begin
         res.active_relay = nxt.fill_phase + 2'd1;
      end
      if (nxt.mode >= MODE_SET1 && nxt.mode <= MODE_SET3) begin
         res.current_share = nxt.share_now;
      end
   end

endmodule

FILE: test/three_relay_timed_fill_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_relay_timed_fill_sequencer_test: self-checking bench for the sequencer
// Drives scheduler ticks through the req stream and checks every rsp
// transaction against an in-bench model of the share setup, the timed fill
// and the safety lockout. It runs six register settings, the first four with
// random stalls on both streams, and ends by locking the block out.
// ----------------------------------------------------------------------------
module three_relay_timed_fill_sequencer_test;
   import trfs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   class fill_scoreboard;
      cfg_type    cfg;
      state_type  st;
      result_type expected_q[$];
      int errors;
      int ticks_seen;
      int results_checked;
      int fills_done;
      int presses_used;

      function new();
         cfg.ticks_per_unit   = TICKS_PER_UNIT_RESET;
         cfg.safety_threshold = SAFETY_THRESHOLD_RESET;
         st = '0;
      endfunction

      function void write_reg(logic idx, logic [9:0] data);
         if (idx == CSR_TICKS_PER_UNIT) begin
            cfg.ticks_per_unit = data[7:0];
         end else begin
            cfg.safety_threshold = data;
         end
      endfunction

      function bit relay_done(logic [1:0] idx);
         return int'(st.tick_count) >= int'(cfg.ticks_per_unit) * int'(st.relay_counts[idx]);
      endfunction

      // One tick of the fill: phases for relays with a zero count are skipped.
      function void advance_fill();
         case (st.fill_phase)
            PHASE_RELAY1: begin
               if (relay_done(2'd0)) begin
                  st.fill_phase = PHASE_RELAY2;
                  if (st.relay_counts[1] == 0) st.fill_phase = st.fill_phase + 2'd1;
                  if (st.relay_counts[2] == 0) st.fill_phase = st.fill_phase + 2'd1;
                  st.tick_count = '0;
               end
            end
            PHASE_RELAY2: begin
               if (relay_done(2'd1)) begin
                  st.fill_phase = (st.relay_counts[2] == 0) ? PHASE_END : PHASE_RELAY3;
                  st.tick_count = '0;
               end
            end
            PHASE_RELAY3: begin
               if (relay_done(2'd2)) begin
                  st.fill_phase = PHASE_END;
                  st.tick_count = '0;
               end
            end
            default: begin
               st.fill_phase = PHASE_RELAY1;
               st.mode       = MODE_IDLE;
               st.tick_count = '0;
               fills_done++;
            end
         endcase
         st.tick_count = st.tick_count + 16'd1;
      endfunction

      function void note_tick(item_type it);
         result_type r;
         logic       consumed;
         bit         room;
         consumed = 1'b0;
         room     = 1'b0;
         ticks_seen++;
         if (st.mode == MODE_FILL) begin
            advance_fill();
         end else if (it.press_pending && st.mode <= MODE_SET3) begin
            if (st.mode != MODE_IDLE && it.button_left) begin
               case (st.mode)
                  MODE_SET1: room = int'(st.share_now) < int'(SHARE_MAX);
                  MODE_SET2: room = int'(st.share_total) + int'(st.share_now) < int'(SHARE_MAX);
                  default:   room = int'(st.share_total) + int'(st.share_now) + int'(SHARE_STEP)
                                    < int'(SHARE_LIMIT);
               endcase
               if (room) st.share_now = st.share_now + SHARE_STEP;
               consumed = 1'b1;
            end
            if (it.button_right) begin
               case (st.mode)
                  MODE_IDLE: st.share_total = '0;
                  MODE_SET1: begin
                     st.relay_counts[0] = 4'(st.share_now / SHARE_STEP);
                     st.share_total     = st.share_now;
                  end
                  MODE_SET2: begin
                     st.share_total     = st.share_total + st.share_now;
                     st.relay_counts[1] = 4'(st.share_now / SHARE_STEP);
                  end
                  default: begin
                     // An empty first relay starts the fill one phase further on.
                     if (st.relay_counts[0] == 0) st.fill_phase = st.fill_phase + 2'd1;
                     st.share_total     = st.share_total + st.share_now;
                     st.relay_counts[2] = 4'(st.share_now / SHARE_STEP);
                  end
               endcase
               if (st.mode != MODE_IDLE) st.share_now = '0;
               st.mode  = st.mode + 3'd1;
               consumed = 1'b1;
            end
         end
         if (it.fluid_level > cfg.safety_threshold) st.mode = MODE_LOCK;
         if (consumed) presses_used++;

         r.mode           = st.mode;
         r.active_relay   = (st.mode == MODE_FILL && st.fill_phase <= PHASE_RELAY3) ?
                            st.fill_phase + 2'd1 : 2'd0;
         r.current_share  = (st.mode >= MODE_SET1 && st.mode <= MODE_SET3) ? st.share_now : '0;
         r.press_consumed = consumed;
         expected_q.push_back(r);
      endfunction

      function bit field_ok(string name, int want, int got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_result(result_type got);
         result_type want;
         bit         good;
         if (expected_q.size() == 0) begin
            $display("%0t ns: result with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         good = field_ok("mode", int'(want.mode), int'(got.mode));
         good = field_ok("active_relay", int'(want.active_relay),
                         int'(got.active_relay)) && good;
         good = field_ok("current_share", int'(want.current_share),
                         int'(got.current_share)) && good;
         good = field_ok("press_consumed", int'(want.press_consumed),
                         int'(got.press_consumed)) && good;
         if (!good) errors++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [9:0]  csr_data = '0;

   fill_scoreboard sb;
   int cycle_count  = 0;
   int send_idle    = 12;
   int recv_idle    = 48;
   int hold_req     = 0;
   int hold_left    = 0;
   int phase_items;
   int lefts_done   = 0;
   int lefts_goal   = 0;
   logic [2:0] seen_mode = MODE_IDLE;

   // Register settings per phase; full-scale rate is written with stray upper bits.
   logic [9:0] rate_plan[6]  = '{10'd1, 10'h3FF, 10'd0, 10'd4, 10'd2, 10'd75};
   logic [9:0] limit_plan[6] = '{10'd1023, 10'd1023, 10'd0, 10'd640, 10'd1023, 10'd150};
   int         lefts_plan[6] = '{11, 1, 11, 11, 11, 1};

   three_relay_timed_fill_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Result side: checks each rsp transaction and throttles rsp_tready.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata[12:0]);
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic item_type make_tick(bit pend, bit right, bit left, int level);
      item_type it;
      it.press_pending = pend;
      it.button_right  = right;
      it.button_left   = left;
      it.fluid_level   = 10'(level);
      return it;
   endfunction

   function automatic int pick_level();
      int ceiling;
      ceiling = int'(sb.cfg.safety_threshold);
      if ($urandom_range(7) == 0) return ceiling;
      return $urandom_range(ceiling, 0);
   endfunction

   // Mostly well-formed setup sequences with a random number of left presses
   // per mode, mixed with random ticks; content is random during a fill.
   function automatic item_type next_tick(int lefts_cap);
      item_type it;
      if (sb.st.mode != seen_mode) begin
         seen_mode  = sb.st.mode;
         lefts_done = 0;
         lefts_goal = $urandom_range(lefts_cap, 0);
      end
      it = make_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                     1'($urandom_range(1, 0)), pick_level());
      if (sb.st.mode != MODE_FILL && $urandom_range(99) >= 15) begin
         it.press_pending = 1'b1;
         if (sb.st.mode >= MODE_SET1 && sb.st.mode <= MODE_SET3 && lefts_done < lefts_goal) begin
            it.button_left  = 1'b1;
            it.button_right = 1'b0;
            lefts_done++;
         end else begin
            it.button_right = 1'b1;
         end
      end
      return it;
   endfunction

   task automatic send_tick(input item_type it);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, it};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_tick(it);
   endtask

   task automatic write_csr(input logic idx, input logic [9:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_TICKS_PER_UNIT, 10'd1);

      // Directed: ignored ticks in idle, a full first share, the share limit
      // in every setup mode, both buttons at once, and a level at threshold.
      send_tick(make_tick(0, 1, 1, 0));
      send_tick(make_tick(1, 0, 1, 1));
      send_tick(make_tick(1, 1, 1, 150));
      repeat (10) send_tick(make_tick(1, 0, 1, $urandom_range(150, 0)));
      send_tick(make_tick(1, 0, 1, 149));
      send_tick(make_tick(0, 1, 1, 2));
      send_tick(make_tick(1, 1, 1, 75));
      send_tick(make_tick(1, 0, 1, 0));
      send_tick(make_tick(1, 1, 0, 150));
      send_tick(make_tick(1, 0, 1, 0));
      send_tick(make_tick(1, 1, 0, 0));
      while (sb.st.mode == MODE_FILL) send_tick(next_tick(0));
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         send_idle = (p < 2) ? 12 : (p < 4) ? 48 : 0;
         recv_idle = (p < 2) ? 48 : (p < 4) ? 12 : 0;
         write_csr(CSR_TICKS_PER_UNIT, rate_plan[p]);
         write_csr(CSR_SAFETY_THRESHOLD, limit_plan[p]);
         phase_items = 0;
         while (phase_items < 200 || sb.st.mode != MODE_IDLE) begin
            if (p == 0 && phase_items == 60) hold_req = 80;
            if (p == 2 && phase_items == 60) wait_drained();
            send_tick(next_tick(lefts_plan[p]));
            phase_items++;
         end
         wait_drained();
      end

      // Lock out in the middle of a fill with a level just over the threshold.
      write_csr(CSR_TICKS_PER_UNIT, 10'd1);
      write_csr(CSR_SAFETY_THRESHOLD, 10'd512);
      while (sb.st.mode != MODE_FILL) send_tick(next_tick(3));
      send_tick(make_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                          1'($urandom_range(1, 0)), 513));
      repeat (20) begin
         send_tick(make_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                             1'($urandom_range(1, 0)), $urandom_range(1023, 0)));
      end
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d ticks under reset defaults and six register settings, from zero",
               sb.ticks_seen);
      $display("to full-scale fill rate; %0d results checked, %0d fills, %0d presses, lockout.",
               sb.results_checked, sb.fills_done, sb.presses_used);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: three_relay_timed_fill_sequencer.f
hw/rtl/trfs_pkg.sv
hw/rtl/trfs_fill.sv
hw/rtl/trfs_step.sv
hw/rtl/three_relay_timed_fill_sequencer.sv
test/three_relay_timed_fill_sequencer_test.sv
